FILE: rtl/iso_date_to_epoch_days_macros.svh
// Assertion helpers shared by the date converter.
`ifndef ISO_DATE_TO_EPOCH_DAYS_MACROS_SVH
`define ISO_DATE_TO_EPOCH_DAYS_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ISOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ISOD_ASSERT_NEVER(label, expr, msg) \
  `ISOD_ASSERT(label, !(expr), msg)

`endif

FILE: rtl/isod_pkg.sv
package isod_pkg;

  typedef logic        [7:0]  char_t;
  typedef logic        [19:0] year_t;
  typedef logic        [6:0]  md_acc_t;
  typedef logic signed [29:0] days_t;

  localparam char_t   CH_DASH = 8'h2D;
  localparam char_t   CH_ZERO = 8'h30;
  localparam char_t   CH_NINE = 8'h39;

  localparam logic [23:0] YEAR_CAP = 24'd999999;
  localparam md_acc_t     MD_SAT   = 7'd99;

  // floor(x / 25) == (x * ERA_RECIP) >> 21 for every 16-bit x
  localparam logic [16:0] ERA_RECIP    = 17'd83887;
  localparam logic [19:0] YEARS_PER_ERA = 20'd400;
  localparam logic [28:0] DAYS_PER_ERA = 29'd146097;
  localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
  localparam logic [29:0] EPOCH_SHIFT  = 30'd719468;

  typedef struct packed {
    year_t      year;
    logic [3:0] month;
    logic [4:0] day;
    logic       err;
  } s1_t;

  typedef struct packed {
    year_t       ya;
    logic [11:0] era;
    logic [8:0]  doy;
    logic        err;
  } s2_t;

  typedef struct packed {
    logic [8:0]  yoe;
    logic [28:0] era_days;
    logic [8:0]  doy;
    logic        err;
  } s3_t;

  typedef struct packed {
    logic [17:0] doe;
    logic [28:0] era_days;
    logic        err;
  } s4_t;

  // Day of year at the first of each month, counted from March.
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/isod_if.sv
interface isod_in_if import isod_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  no_byte;
  logic  last;

  modport source (output valid, output char_code, output no_byte, output last, input ready);
  modport sink (input valid, input char_code, input no_byte, input last, output ready);
endinterface

interface isod_out_if import isod_pkg::*; ();
  logic  valid;
  logic  ready;
  days_t days;
  logic  error;

  modport source (output valid, output days, output error, input ready);
  modport sink (input valid, input days, input error, output ready);
endinterface

FILE: rtl/iso_date_to_epoch_days.sv
// After its last byte is accepted, a result passes the stage 1-4 registers and the output
// register. Bytes are taken one per cycle and the four conversion stages each take one new
// date per cycle; requests are held off only when the chain is full and the output is stalled.
// Reset (rst_ni low, asynchronous) clears the field phase, accumulators, error flag and
// every stage valid; no result is pending after reset.
`include "iso_date_to_epoch_days_macros.svh"

module iso_date_to_epoch_days import isod_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  isod_in_if.sink    in_i,
  isod_out_if.source out_o
);

  localparam logic [1:0] PH_YEAR  = 2'd0;
  localparam logic [1:0] PH_MONTH = 2'd1;
  localparam logic [1:0] PH_DAY   = 2'd2;
  localparam logic [1:0] PH_SPARE = 2'd3;

  logic [1:0] phase_q, phase_d, phase_upd;
  year_t      year_acc_q, year_acc_d, year_upd;
  md_acc_t    month_acc_q, month_acc_d, month_upd;
  md_acc_t    day_acc_q, day_acc_d, day_upd;
  logic       bad_q, bad_d, bad_upd;

  logic        in_acc;
  logic        is_digit, is_dash;
  logic [3:0]  dig;
  logic [23:0] year_mul;
  logic [9:0]  month_mul, day_mul;

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  s3_t   s3_d, s3_q;
  s4_t   s4_d, s4_q;
  days_t days_d, days_q;
  logic  err_q;

  // ready chain: a stage loads when it is empty or its successor loads
  assign rdy5 = !out_vld_q || out_o.ready;
  assign rdy4 = !s4_vld_q || rdy5;
  assign rdy3 = !s3_vld_q || rdy4;
  assign rdy2 = !s2_vld_q || rdy3;
  assign rdy1 = !s1_vld_q || rdy2;

  assign in_i.ready = rdy1;
  assign in_acc     = in_i.valid && rdy1;

  // field accumulation
  assign is_digit  = (in_i.char_code >= CH_ZERO) && (in_i.char_code <= CH_NINE);
  assign is_dash   = (in_i.char_code == CH_DASH);
  assign dig       = is_digit ? in_i.char_code[3:0] : 4'd0;
  assign year_mul  = {1'b0, year_acc_q, 3'b000} + {3'b000, year_acc_q, 1'b0} + 24'(dig);
  assign month_mul = {month_acc_q, 3'b000} + {2'b00, month_acc_q, 1'b0} + 10'(dig);
  assign day_mul   = {day_acc_q, 3'b000} + {2'b00, day_acc_q, 1'b0} + 10'(dig);

  always_comb begin
    phase_upd = phase_q;
    year_upd  = year_acc_q;
    month_upd = month_acc_q;
    day_upd   = day_acc_q;
    bad_upd   = bad_q;
    if (!in_i.no_byte && !bad_q) begin
      case (phase_q)
        PH_YEAR: begin
          if (is_dash) begin
            phase_upd = PH_MONTH;
          end else if (is_digit) begin
            if (year_mul > YEAR_CAP) bad_upd = 1'b1;
            else year_upd = year_mul[19:0];
          end else begin
            bad_upd = 1'b1;
          end
        end
        PH_MONTH: begin
          if (is_dash) begin
            phase_upd = PH_DAY;
          end else if (is_digit) begin
            month_upd = (month_mul > 10'(MD_SAT)) ? MD_SAT : month_mul[6:0];
          end else begin
            bad_upd = 1'b1;
          end
        end
        default: begin
          if (is_digit) day_upd = (day_mul > 10'(MD_SAT)) ? MD_SAT : day_mul[6:0];
          else bad_upd = 1'b1;
        end
      endcase
    end
  end

  // clear after the last byte so the next string starts fresh
  always_comb begin
    phase_d     = phase_q;
    year_acc_d  = year_acc_q;
    month_acc_d = month_acc_q;
    day_acc_d   = day_acc_q;
    bad_d       = bad_q;
    if (in_acc) begin
      if (in_i.last) begin
        phase_d     = PH_YEAR;
        year_acc_d  = '0;
        month_acc_d = '0;
        day_acc_d   = '0;
        bad_d       = 1'b0;
      end else begin
        phase_d     = phase_upd;
        year_acc_d  = year_upd;
        month_acc_d = month_upd;
        day_acc_d   = day_upd;
        bad_d       = bad_upd;
      end
    end
  end

  // stage 1: final field values and validity
  always_comb begin
    s1_d.year  = year_upd;
    s1_d.month = month_upd[3:0];
    s1_d.day   = day_upd[4:0];
    s1_d.err   = bad_upd || (phase_upd == PH_YEAR) || (phase_upd == PH_MONTH) ||
                 (year_upd == '0) || (month_upd == '0) || (month_upd > 7'd12) ||
                 (day_upd == '0) || (day_upd > 7'd31);
  end

  // stage 2: shift the year to start in March, split off the 400-year era
  logic [3:0]  mp;
  logic [32:0] era_prod;
  always_comb begin
    s2_d.ya  = (s1_q.month <= 4'd2) ? s1_q.year - 20'd1 : s1_q.year;
    era_prod = 33'(s2_d.ya[19:4]) * 33'(ERA_RECIP);
    s2_d.era = era_prod[32:21];
    mp       = (s1_q.month > 4'd2) ? s1_q.month - 4'd3 : s1_q.month + 4'd9;
    s2_d.doy = month_offset(mp) + 9'(s1_q.day) - 9'd1;
    s2_d.err = s1_q.err;
  end

  // stage 3: year of era and days of the whole eras
  logic [19:0] era_years;
  always_comb begin
    era_years     = 20'(s2_q.era) * YEARS_PER_ERA;
    s3_d.yoe      = 9'(s2_q.ya - era_years);
    s3_d.era_days = 29'(s2_q.era) * DAYS_PER_ERA;
    s3_d.doy      = s2_q.doy;
    s3_d.err      = s2_q.err;
  end

  // stage 4: day of era
  logic [1:0] cent;
  always_comb begin
    if (s3_q.yoe >= 9'd300)      cent = 2'd3;
    else if (s3_q.yoe >= 9'd200) cent = 2'd2;
    else if (s3_q.yoe >= 9'd100) cent = 2'd1;
    else                         cent = 2'd0;
    s4_d.doe = 18'(s3_q.yoe) * DAYS_PER_YEAR + 18'(s3_q.yoe[8:2]) - 18'(cent) +
               18'(s3_q.doy);
    s4_d.era_days = s3_q.era_days;
    s4_d.err      = s3_q.err;
  end

  // stage 5: rebase to the epoch
  assign days_d = s4_q.err ? '0 :
                  days_t'(30'(s4_q.era_days) + 30'(s4_q.doe) - EPOCH_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_YEAR;
      year_acc_q  <= '0;
      month_acc_q <= '0;
      day_acc_q   <= '0;
      bad_q       <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      year_acc_q  <= year_acc_d;
      month_acc_q <= month_acc_d;
      day_acc_q   <= day_acc_d;
      bad_q       <= bad_d;
      if (rdy1) s1_vld_q  <= in_acc && in_i.last;
      if (rdy2) s2_vld_q  <= s1_vld_q;
      if (rdy3) s3_vld_q  <= s2_vld_q;
      if (rdy4) s4_vld_q  <= s3_vld_q;
      if (rdy5) out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
    if (rdy4) s4_q <= s4_d;
    if (rdy5) begin
      days_q <= days_d;
      err_q  <= s4_q.err;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.days  = days_q;
  assign out_o.error = err_q;

  `ISOD_ASSERT_NEVER(a_phase_spare, phase_q == PH_SPARE, "phase reached unused code")
  `ISOD_ASSERT(a_clear_after_last, in_acc && in_i.last |=> phase_q == PH_YEAR && year_acc_q == '0 && month_acc_q == '0 && day_acc_q == '0 && !bad_q, "state not cleared after last byte")
  `ISOD_ASSERT_NEVER(a_year_cap, 24'(year_acc_q) > YEAR_CAP, "year accumulator above cap")
  `ISOD_ASSERT_NEVER(a_md_sat, month_acc_q > MD_SAT || day_acc_q > MD_SAT, "month or day above saturation")
  `ISOD_ASSERT(a_days_range, out_vld_q && !err_q |-> days_q >= -30'sd719162 && days_q <= 30'sd365242500, "day count out of range")

endmodule
